// ----- hw/rtl/adq_pkg.sv -----
// shared types and constants for the ascii decimal to q32.32 converter
// no dependencies

package adq_pkg;

    localparam int INT_W   = 32;
    localparam int FRAC_W  = 30;
    localparam int CNT_W   = 4;
    localparam int QUO_W   = 32;
    localparam int STEP_W  = 5;
    localparam int Q_DEPTH = 2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [3:0] {
        PH_LEAD = 4'b0001,
        PH_INT  = 4'b0010,
        PH_FRAC = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } t_back_state;

    typedef struct packed {
        logic              neg;
        logic [INT_W-1:0]  whole;
        logic [FRAC_W-1:0] frac;
        logic [CNT_W-1:0]  cnt;
    } t_job;

    function automatic logic [FRAC_W-1:0] pow10(input logic [CNT_W-1:0] n);
        logic [FRAC_W-1:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

// ----- hw/rtl/adq_front.sv -----
// front end: accepts characters and runs the parse state machine
// depends on adq_pkg; hands finished strings to the job queue

module adq_front
    import adq_pkg::*;
#(
    parameter int MAX_FRACTION_DIGITS = 9
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_char_present,
    input  logic       i_is_last,
    output logic       o_push,
    output t_job       o_job,
    input  logic       i_full
);

    t_phase            r_phase, n_phase;
    logic              r_neg, n_neg;
    logic [INT_W-1:0]  r_int, n_int;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic       accept;
    logic       is_digit;
    logic [3:0] digit;
    logic [7:0] c;

    assign o_stall  = i_full;
    assign accept   = i_valid && !i_full;
    assign c        = i_char_code;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign digit    = 4'(c - CH_ZERO);

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_int   = r_int;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        if (i_char_present) begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (c == CH_SPACE || c == CH_TAB) begin
                        n_phase = PH_LEAD;
                    end else if (c == CH_PLUS || c == CH_MINUS) begin
                        n_neg   = (c == CH_MINUS);
                        n_phase = PH_INT;
                    end else if (is_digit) begin
                        n_int   = (r_int << 3) + (r_int << 1) + {28'd0, digit};
                        n_phase = PH_INT;
                    end else if (c == CH_POINT) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_INT: begin
                    if (is_digit) begin
                        n_int = (r_int << 3) + (r_int << 1) + {28'd0, digit};
                    end else if (c == CH_POINT) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_FRAC: begin
                    if (is_digit && (r_cnt < CNT_W'(MAX_FRACTION_DIGITS))) begin
                        n_frac = (r_frac << 3) + (r_frac << 1) + {26'd0, digit};
                        n_cnt  = r_cnt + 4'd1;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    assign o_push = accept && i_is_last;
    always_comb begin
        o_job.neg   = n_neg;
        o_job.whole = n_int;
        o_job.frac  = n_frac;
        o_job.cnt   = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_is_last)) begin
            r_phase <= PH_LEAD;
            r_neg   <= 1'b0;
            r_int   <= '0;
            r_frac  <= '0;
            r_cnt   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- hw/rtl/adq_queue.sv -----
// two-entry job queue between the parser and the divider
// depends on adq_pkg

module adq_queue
    import adq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job       r_mem [Q_DEPTH];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'(Q_DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ----- hw/rtl/adq_back.sv -----
// back end: radix-2 fraction divide by a power of ten, sign and output register
// depends on adq_pkg; pulls jobs from adq_queue

module adq_back
    import adq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [63:0] o_fixed_value
);

    t_back_state       r_state;
    logic              r_neg;
    logic [INT_W-1:0]  r_int;
    logic [FRAC_W-1:0] r_rem;
    logic [FRAC_W-1:0] r_div;
    logic [QUO_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic [63:0]       r_out;

    logic [FRAC_W:0]   trial;
    logic              sub_ok;
    logic [FRAC_W-1:0] n_rem;
    logic [63:0]       mag;
    logic              out_free;

    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign trial    = {r_rem, 1'b0};
    assign sub_ok   = (trial >= {1'b0, r_div});
    assign n_rem    = sub_ok ? FRAC_W'(trial - {1'b0, r_div}) : trial[FRAC_W-1:0];
    assign mag      = {r_int, r_quo};
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= ST_DIV;
                        r_step  <= '0;
                    end
                end
                ST_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(QUO_W - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_neg <= i_job.neg;
            r_int <= i_job.whole;
            r_rem <= i_job.frac;
            r_div <= pow10(i_job.cnt);
            r_quo <= '0;
        end else if (r_state == ST_DIV) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QUO_W-2:0], sub_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && out_free) begin
            r_out <= r_neg ? (64'd0 - mag) : mag;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_fixed_value = signed'(r_out);

endmodule

// ----- hw/rtl/ascii_decimal_to_q32_32.sv -----
// top level: ascii decimal string to signed q32.32, one character word per cycle
// front parser takes a word every cycle while the job queue has room
// back divider takes one string at a time: load, one quotient bit per step for 32 bits, output
// a string's result goes through the job queue, the idle, divide and finish states and the output register to o_valid
// reset is synchronous, active low; parser, queue and output valid are cleared
// depends on adq_pkg, adq_front, adq_queue, adq_back

module ascii_decimal_to_q32_32
    import adq_pkg::*;
#(
    parameter int MAX_FRACTION_DIGITS = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_char_present,
    input  logic               i_is_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [63:0] o_fixed_value
);

    logic push, full, q_valid, pop;
    t_job push_job, q_job;

    adq_front #(
        .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_code   (i_char_code),
        .i_char_present(i_char_present),
        .i_is_last     (i_is_last),
        .o_push        (push),
        .o_job         (push_job),
        .i_full        (full)
    );

    adq_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .o_full (full),
        .o_valid(q_valid),
        .o_job  (q_job),
        .i_pop  (pop)
    );

    adq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_job        (q_job),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_fixed_value(o_fixed_value)
    );

endmodule

// ----- hw/rtl/adq_checker.sv -----
// port-level checks for ascii_decimal_to_q32_32, attached by bind
// no package dependencies

module adq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [63:0] o_fixed_value
);

    // reset drops any pending result
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // reset empties the job queue so input is not stalled
    a_reset_stall: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_fixed_value))
        else $error("stalled result word changed");

    // words offered during reset never produce a result
    a_in_quiet: assert property (@(posedge i_clk)
        !i_rst_n && i_valid |=> !o_valid)
        else $error("result valid after reset with input active");

endmodule

bind ascii_decimal_to_q32_32 adq_checker u_adq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_fixed_value(o_fixed_value)
);

// ----- dv/testbench.sv -----
// testbench for ascii_decimal_to_q32_32: directed strings, then random well-formed and noisy text
// a built-in parser model predicts each q32.32 result not given by a directed row, checked in order with random idling
// depends on adq_pkg and the ascii_decimal_to_q32_32 rtl
`timescale 1ns / 1ps

module testbench
    import adq_pkg::*;
();

    localparam int FRAC_DIGITS_MAX = 9;
    localparam int N_DIRECTED      = 41;
    localparam int N_RANDOM        = 1400;
    localparam int N_QUIET_TAIL    = 200;

    typedef struct packed {
        logic [7:0]  code;
        logic        present;
        logic        last;
        logic        known;
        logic [63:0] value;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_char_code;
    logic               i_char_present;
    logic               i_is_last;
    logic               o_valid;
    logic               i_stall;
    logic signed [63:0] o_fixed_value;

    t_phase      accum_phase;
    logic        accum_neg;
    logic [31:0] accum_whole;
    logic [29:0] accum_frac;
    logic [3:0]  accum_digits;

    logic [63:0] expected_values[$];
    logic [7:0]  text_chars[$];
    logic [63:0] want_value;
    int          n_errors    = 0;
    int          words_sent  = 0;
    int          idle_pct    = 0;
    bit          quiet       = 1'b0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 64'h0},
        '{CH_MINUS, 1'b1, 1'b1, 1'b1, 64'h0},
        '{CH_POINT, 1'b1, 1'b1, 1'b1, 64'h0},
        '{CH_SPACE, 1'b1, 1'b0, 1'b0, 64'h0},
        '{CH_MINUS, 1'b1, 1'b0, 1'b0, 64'h0},
        '{"1", 1'b1, 1'b0, 1'b0, 64'h0},
        '{CH_POINT, 1'b1, 1'b0, 1'b0, 64'h0},
        '{"5", 1'b1, 1'b1, 1'b1, 64'hFFFF_FFFE_8000_0000},
        '{"1", 1'b1, 1'b0, 1'b0, 64'h0},
        '{CH_PLUS, 1'b1, 1'b0, 1'b0, 64'h0},
        '{"7", 1'b1, 1'b1, 1'b1, 64'h0000_0001_0000_0000},
        '{CH_POINT, 1'b1, 1'b0, 1'b0, 64'h0},
        '{"5", 1'b1, 1'b0, 1'b0, 64'h0},
        '{CH_POINT, 1'b1, 1'b0, 1'b0, 64'h0},
        '{"5", 1'b1, 1'b1, 1'b1, 64'h0000_0000_8000_0000},
        '{CH_TAB, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h00, 1'b1, 1'b1, 1'b1, 64'h0},
        '{CH_MINUS, 1'b1, 1'b0, 1'b0, 64'h0},
        '{"2", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"1", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"4", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"7", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"4", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"8", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"3", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"6", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"4", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"8", 1'b1, 1'b1, 1'b1, 64'h8000_0000_0000_0000},
        '{CH_POINT, 1'b1, 1'b0, 1'b0, 64'h0},
        '{"1", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"1", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"1", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"1", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"1", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"1", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"1", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"1", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"1", 1'b1, 1'b0, 1'b0, 64'h0},
        '{"2", 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 64'h0}
    };

    ascii_decimal_to_q32_32 #(
        .MAX_FRACTION_DIGITS(FRAC_DIGITS_MAX)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_char_present (i_char_present),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_fixed_value  (o_fixed_value)
    );

    function automatic void clear_parse();
        accum_phase  = PH_LEAD;
        accum_neg    = 1'b0;
        accum_whole  = '0;
        accum_frac   = '0;
        accum_digits = '0;
    endfunction

    function automatic void absorb_char(input logic [7:0] c);
        logic is_digit;
        logic [7:0] d;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d = c - CH_ZERO;
        case (accum_phase)
            PH_LEAD: begin
                if (c == CH_SPACE || c == CH_TAB) begin
                    accum_phase = PH_LEAD;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    accum_neg   = (c == CH_MINUS);
                    accum_phase = PH_INT;
                end else if (is_digit) begin
                    accum_whole = accum_whole * 32'd10 + 32'(d);
                    accum_phase = PH_INT;
                end else if (c == CH_POINT) begin
                    accum_phase = PH_FRAC;
                end else begin
                    accum_phase = PH_DONE;
                end
            end
            PH_INT: begin
                if (is_digit) begin
                    accum_whole = accum_whole * 32'd10 + 32'(d);
                end else if (c == CH_POINT) begin
                    accum_phase = PH_FRAC;
                end else begin
                    accum_phase = PH_DONE;
                end
            end
            PH_FRAC: begin
                if (is_digit && accum_digits < FRAC_DIGITS_MAX) begin
                    accum_frac   = accum_frac * 30'd10 + 30'(d);
                    accum_digits = accum_digits + 4'd1;
                end else begin
                    accum_phase = PH_DONE;
                end
            end
            default: begin
                accum_phase = PH_DONE;
            end
        endcase
    endfunction

    function automatic logic [63:0] q32_value();
        logic [63:0] divisor;
        logic [63:0] v;
        int          n;
        n = (accum_digits > 4'd9) ? 9 : int'(accum_digits);
        divisor = 64'd1;
        for (int k = 0; k < n; k++) begin
            divisor = divisor * 64'd10;
        end
        v = {accum_whole, 32'd0} + (({34'd0, accum_frac}) << 32) / divisor;
        return accum_neg ? 64'd0 - v : v;
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_noise_char();
        case ($urandom_range(0, 7))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_PLUS;
            3: return CH_MINUS;
            4: return CH_POINT;
            5: return rand_digit();
            6: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void build_text();
        int n;
        text_chars.delete();
        if ($urandom_range(0, 99) < 80) begin
            n = $urandom_range(0, 2);
            for (int k = 0; k < n; k++) begin
                text_chars = {text_chars, ($urandom_range(0, 1) ? CH_SPACE : CH_TAB)};
            end
            if ($urandom_range(0, 1)) begin
                text_chars = {text_chars, ($urandom_range(0, 1) ? CH_MINUS : CH_PLUS)};
            end
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 6);
            for (int k = 0; k < n; k++) begin
                text_chars = {text_chars, rand_digit()};
            end
            if ($urandom_range(0, 99) < 60) begin
                text_chars = {text_chars, CH_POINT};
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 11)
                                                : $urandom_range(0, 5);
                for (int k = 0; k < n; k++) begin
                    text_chars = {text_chars, rand_digit()};
                end
            end
            if ($urandom_range(0, 99) < 20) begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++) begin
                    text_chars = {text_chars, rand_noise_char()};
                end
            end
        end else begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
                text_chars = {text_chars, rand_noise_char()};
            end
        end
    endfunction

    task automatic send_word(input logic [7:0] code, input logic present,
                             input logic last, input logic known,
                             input logic [63:0] value);
        int gap;
        gap = (!quiet && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 15) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_char_code    <= code;
        i_char_present <= present;
        i_is_last      <= last;
        do @(posedge i_clk); while (o_stall);
        if (present) begin
            absorb_char(code);
        end
        if (last) begin
            expected_values = {expected_values, (known ? value : q32_value())};
            clear_parse();
        end
        words_sent++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    // receiver back-pressure
    initial begin
        i_stall <= 1'b0;
        forever begin
            if (quiet) begin
                @(negedge i_clk) i_stall <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(50, 150)) @(negedge i_clk) i_stall <= 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 15)) @(negedge i_clk) i_stall <= 1'b1;
            end else begin
                repeat ($urandom_range(1, 15)) @(negedge i_clk) i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_values.size() == 0) begin
                $error("fixed_value: expected none, got %h", o_fixed_value);
                n_errors++;
            end else begin
                want_value = expected_values.pop_front();
                if (o_fixed_value !== want_value) begin
                    $error("fixed_value: expected %h, got %h", want_value, o_fixed_value);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        int target;
        bit bare_end;
        clear_parse();
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_char_code    <= '0;
        i_char_present <= 1'b0;
        i_is_last      <= 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        idle_pct = 30;
        foreach (directed_rows[k]) begin
            send_word(directed_rows[k].code, directed_rows[k].present,
                      directed_rows[k].last, directed_rows[k].known,
                      directed_rows[k].value);
        end
        @(negedge i_clk) i_valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge i_clk);

        target = words_sent + N_RANDOM;
        while (words_sent < target) begin
            quiet = (words_sent > target - N_QUIET_TAIL);
            if ($urandom_range(0, 14) == 0) begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 5;
                    2: idle_pct = 25;
                    default: idle_pct = 50;
                endcase
            end
            build_text();
            bare_end = (text_chars.size() == 0) || ($urandom_range(0, 99) < 30);
            foreach (text_chars[k]) begin
                if ($urandom_range(0, 99) < 5) begin
                    send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 64'h0);
                end
                send_word(text_chars[k], 1'b1,
                          !bare_end && (k == text_chars.size() - 1), 1'b0, 64'h0);
            end
            if (bare_end) begin
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 64'h0);
            end
        end
        @(negedge i_clk) i_valid <= 1'b0;

        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
